// ----- rtl/core/crdb_pkg.sv -----
// crdb_pkg: shared types and constants of the csr row degree binner
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package crdb_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SMALL_LIMIT = 3'd0,
    CFG_LARGE_LIMIT = 3'd1,
    CFG_TOTAL_EDGES = 3'd2,
    CFG_TOTAL_ROWS  = 3'd3,
    CFG_BIN0_CAP    = 3'd4,
    CFG_BIN1_CAP    = 3'd5,
    CFG_BIN2_CAP    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BIN_SMALL  = 2'd0,
    BIN_MEDIUM = 2'd1,
    BIN_LARGE  = 2'd2
  } bin_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_THRESH  = 2'd1,
    ST_BAD_OFFSETS = 2'd2,
    ST_OVER_CAP    = 2'd3
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] small_limit;
    logic [DataW-1:0] large_limit;
    logic [DataW-1:0] total_edges;
    logic [DataW-1:0] total_rows;
    logic [DataW-1:0] bin0_cap;
    logic [DataW-1:0] bin1_cap;
    logic [DataW-1:0] bin2_cap;
  } cfg_t;

  // classified row handed from front to back
  typedef struct packed {
    logic             has_row;
    logic [DataW-1:0] row_index;
    bin_e             bin;
    logic             last;
    status_e          status;
  } job_t;

  typedef struct packed {
    logic             has_row;
    logic [DataW-1:0] row_index;
    logic [1:0]       bin;
    logic             last;
    logic [1:0]       status;
    logic [DataW-1:0] bin0_rows;
    logic [DataW-1:0] bin1_rows;
    logic [DataW-1:0] bin2_rows;
  } res_t;

endpackage

// ----- rtl/core/crdb_in_if.sv -----
// crdb_in_if: offset input channel of the csr row degree binner
// depends on crdb_pkg
`timescale 1ns / 1ps

interface crdb_in_if;
  logic                      valid;
  logic                      ready;
  logic [crdb_pkg::DataW-1:0] offset;

  modport source (output valid, output offset, input ready);
  modport sink   (input valid, input offset, output ready);
endinterface

// ----- rtl/core/crdb_out_if.sv -----
// crdb_out_if: result channel of the csr row degree binner
// depends on crdb_pkg
`timescale 1ns / 1ps

interface crdb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       has_row;
  logic [crdb_pkg::DataW-1:0] row_index;
  logic [1:0]                 bin;
  logic                       last;
  logic [1:0]                 status;
  logic [crdb_pkg::DataW-1:0] bin0_rows;
  logic [crdb_pkg::DataW-1:0] bin1_rows;
  logic [crdb_pkg::DataW-1:0] bin2_rows;

  modport source (output valid, output has_row, output row_index, output bin, output last,
                  output status, output bin0_rows, output bin1_rows, output bin2_rows,
                  input ready);
  modport sink   (input valid, input has_row, input row_index, input bin, input last,
                  input status, input bin0_rows, input bin1_rows, input bin2_rows,
                  output ready);
endinterface

// ----- rtl/core/crdb_cfg_if.sv -----
// crdb_cfg_if: configuration write channel of the csr row degree binner
// depends on crdb_pkg
`timescale 1ns / 1ps

interface crdb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [crdb_pkg::CfgIdxW-1:0] index;
  logic [crdb_pkg::DataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/crdb_cfg_regs.sv -----
// crdb_cfg_regs: configuration register file, one write per cycle
// depends on crdb_pkg and crdb_cfg_if
`timescale 1ns / 1ps

module crdb_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  crdb_cfg_if.sink          cfg_i,
  output crdb_pkg::cfg_t    cfg_o
);

  crdb_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{large_limit: crdb_pkg::DataW'(1), default: '0};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        crdb_pkg::CFG_SMALL_LIMIT: cfg_q.small_limit <= cfg_i.data;
        crdb_pkg::CFG_LARGE_LIMIT: cfg_q.large_limit <= cfg_i.data;
        crdb_pkg::CFG_TOTAL_EDGES: cfg_q.total_edges <= cfg_i.data;
        crdb_pkg::CFG_TOTAL_ROWS:  cfg_q.total_rows  <= cfg_i.data;
        crdb_pkg::CFG_BIN0_CAP:    cfg_q.bin0_cap    <= cfg_i.data;
        crdb_pkg::CFG_BIN1_CAP:    cfg_q.bin1_cap    <= cfg_i.data;
        crdb_pkg::CFG_BIN2_CAP:    cfg_q.bin2_cap    <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/crdb_front.sv -----
// crdb_front: accepts offsets, computes row degree, bin, threshold and offset checks
// depends on crdb_pkg and crdb_in_if
`timescale 1ns / 1ps

module crdb_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  crdb_in_if.sink         in_i,
  input  crdb_pkg::cfg_t  cfg_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output crdb_pkg::job_t  job_o
);

  localparam int unsigned OffW = (VALUE_WIDTH < crdb_pkg::DataW) ? VALUE_WIDTH
                                                                  : crdb_pkg::DataW;

  logic [OffW-1:0]            prev_q;
  logic [crdb_pkg::DataW-1:0] seen_q;
  logic                       bad_q;

  logic [OffW-1:0] v, small_lim, large_lim, edges, deg;
  logic            has_row, last, emit, bad_now, table_bad, accept;

  always_comb begin
    v         = in_i.offset[OffW-1:0];
    small_lim = cfg_i.small_limit[OffW-1:0];
    large_lim = cfg_i.large_limit[OffW-1:0];
    edges     = cfg_i.total_edges[OffW-1:0];
    has_row   = seen_q != '0;
    last      = seen_q == cfg_i.total_rows;
    emit      = has_row || last;
    deg       = v - prev_q;
    bad_now   = bad_q || (has_row && (v < prev_q)) || (!has_row && (v != '0));

    if (cfg_i.total_rows == '0) begin
      table_bad = edges != '0;
    end else begin
      table_bad = bad_now || (v != edges);
    end

    job_o.has_row   = has_row;
    job_o.last      = last;
    job_o.row_index = has_row ? (seen_q - crdb_pkg::DataW'(1)) : '0;

    if (!has_row) begin
      job_o.bin = crdb_pkg::BIN_SMALL;
    end else if (deg <= small_lim) begin
      job_o.bin = crdb_pkg::BIN_SMALL;
    end else if (deg <= large_lim) begin
      job_o.bin = crdb_pkg::BIN_MEDIUM;
    end else begin
      job_o.bin = crdb_pkg::BIN_LARGE;
    end

    if (!last) begin
      job_o.status = crdb_pkg::ST_OK;
    end else if (small_lim >= large_lim) begin
      job_o.status = crdb_pkg::ST_BAD_THRESH;
    end else if (table_bad) begin
      job_o.status = crdb_pkg::ST_BAD_OFFSETS;
    end else begin
      job_o.status = crdb_pkg::ST_OK;
    end
  end

  assign in_i.ready  = job_ready_i;
  assign job_valid_o = in_i.valid && emit;
  assign accept      = in_i.valid && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      seen_q <= '0;
      bad_q  <= 1'b0;
    end else if (accept) begin
      if (last) begin
        prev_q <= '0;
        seen_q <= '0;
        bad_q  <= 1'b0;
      end else begin
        prev_q <= v;
        seen_q <= seen_q + crdb_pkg::DataW'(1);
        bad_q  <= bad_now;
      end
    end
  end

endmodule

// ----- rtl/core/crdb_queue.sv -----
// crdb_queue: short job queue between classifier front and counting back
// depends on crdb_pkg
`timescale 1ns / 1ps

module crdb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  crdb_pkg::job_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output crdb_pkg::job_t  pop_data_o
);

  localparam int unsigned PtrW = (crdb_pkg::QueueDepth > 1) ? $clog2(crdb_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(crdb_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(crdb_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(crdb_pkg::QueueDepth);

  crdb_pkg::job_t  mem_q [crdb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/crdb_back.sv -----
// crdb_back: per-bin row counters, capacity check and result register
// depends on crdb_pkg and crdb_out_if
`timescale 1ns / 1ps

module crdb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  crdb_pkg::job_t  job_i,
  input  crdb_pkg::cfg_t  cfg_i,
  crdb_out_if.source      out_o
);

  logic [crdb_pkg::DataW-1:0] cnt0_q, cnt1_q, cnt2_q;
  logic [crdb_pkg::DataW-1:0] cnt0_d, cnt1_d, cnt2_d;
  logic                       out_valid_q;
  crdb_pkg::res_t             res_q, res_d;
  crdb_pkg::status_e          status;
  logic                       pop;

  assign job_ready_o = !out_valid_q || out_o.ready;
  assign pop         = job_valid_i && job_ready_o;

  always_comb begin
    cnt0_d = cnt0_q;
    cnt1_d = cnt1_q;
    cnt2_d = cnt2_q;
    if (job_i.has_row) begin
      case (job_i.bin)
        crdb_pkg::BIN_SMALL:  cnt0_d = cnt0_q + crdb_pkg::DataW'(1);
        crdb_pkg::BIN_MEDIUM: cnt1_d = cnt1_q + crdb_pkg::DataW'(1);
        default:              cnt2_d = cnt2_q + crdb_pkg::DataW'(1);
      endcase
    end

    if (job_i.status != crdb_pkg::ST_OK) begin
      status = job_i.status;
    end else if (job_i.last && ((cnt0_d > cfg_i.bin0_cap) || (cnt1_d > cfg_i.bin1_cap) ||
                                (cnt2_d > cfg_i.bin2_cap))) begin
      status = crdb_pkg::ST_OVER_CAP;
    end else begin
      status = crdb_pkg::ST_OK;
    end

    res_d.has_row   = job_i.has_row;
    res_d.row_index = job_i.row_index;
    res_d.bin       = job_i.bin;
    res_d.last      = job_i.last;
    res_d.status    = status;
    res_d.bin0_rows = cnt0_d;
    res_d.bin1_rows = cnt1_d;
    res_d.bin2_rows = cnt2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt0_q      <= '0;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
        if (job_i.last) begin
          cnt0_q <= '0;
          cnt1_q <= '0;
          cnt2_q <= '0;
        end else begin
          cnt0_q <= cnt0_d;
          cnt1_q <= cnt1_d;
          cnt2_q <= cnt2_d;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.has_row   = res_q.has_row;
  assign out_o.row_index = res_q.row_index;
  assign out_o.bin       = res_q.bin;
  assign out_o.last      = res_q.last;
  assign out_o.status    = res_q.status;
  assign out_o.bin0_rows = res_q.bin0_rows;
  assign out_o.bin1_rows = res_q.bin1_rows;
  assign out_o.bin2_rows = res_q.bin2_rows;

endmodule

// ----- rtl/core/csr_row_degree_binner_top.sv -----
// csr_row_degree_binner_top: sorts csr rows into three degree bins
// depends on crdb_pkg, the crdb interfaces, crdb_cfg_regs, crdb_front, crdb_queue, crdb_back
//
//   channel  dir  word
//   in_i     in   offset (32)
//   out_o    out  has_row, row_index, bin, last, status, bin0_rows..bin2_rows
//   cfg_i    in   index (3), data (32); ready always high
//
// one offset word per cycle sustained while out_o accepts results; each result passes
// the front classifier, then the two-entry queue, then the back result register
// the first offset of a table gives no result unless the table is empty
// reset clears counters, stream state and queue; registers take their reset values
// a stalled out_o fills the queue, after which in_i.ready drops

`timescale 1ns / 1ps

module csr_row_degree_binner_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crdb_in_if.sink    in_i,
  crdb_out_if.source out_o,
  crdb_cfg_if.sink   cfg_i
);

  crdb_pkg::cfg_t cfg;
  crdb_pkg::job_t push_job, pop_job;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  crdb_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  crdb_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  crdb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  crdb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .cfg_i       (cfg),
    .out_o       (out_o)
  );

endmodule

// ----- tb/sv/csr_row_degree_binner_top_tb.sv -----
// csr_row_degree_binner_top_tb: self-checking bench for the csr row degree binner
// directed tables and then random offset tables, checked against a predictor of the binning
// depends on crdb_pkg, crdb_in_if, crdb_out_if, crdb_cfg_if and csr_row_degree_binner_top
`timescale 1ns / 1ps

module csr_row_degree_binner_top_tb;
  import crdb_pkg::*;

  localparam int unsigned RandomOffsets = 1450;
  localparam int unsigned SteadyFrom    = 500;
  localparam int unsigned SteadyTo      = 800;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned NumSteps      = 41;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [31:0] value;
    bit          typed;
    res_t        want;
  } step_t;

  logic clk;
  logic rst_n;

  crdb_in_if  in_if ();
  crdb_out_if out_if ();
  crdb_cfg_if cfg_if ();

  csr_row_degree_binner_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // register shadow, reset values
  logic [31:0] lim_small = 32'd0;
  logic [31:0] lim_large = 32'd1;
  logic [31:0] edges_cfg = 32'd0;
  logic [31:0] rows_cfg  = 32'd0;
  logic [31:0] cap [3]   = '{32'd0, 32'd0, 32'd0};

  // table state
  logic [31:0] prev_off  = 32'd0;
  logic [31:0] seen      = 32'd0;
  logic [31:0] cnt [3]   = '{32'd0, 32'd0, 32'd0};
  bit          off_bad   = 1'b0;

  res_t        pending_rows [$];
  int unsigned errors       = 0;
  int unsigned offsets_sent = 0;
  int unsigned quiet        = 0;
  bit          steady       = 1'b0;
  step_t       plan [NumSteps];

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // bins one offset; returns 1 when the offset closes a row or ends the table
  function automatic bit classify_offset(input logic [31:0] v, output res_t r);
    logic [31:0] deg;
    bin_e        b;
    status_e     st;
    bit          has, last, bad;
    r    = '0;
    has  = seen != 0;
    last = seen == rows_cfg;
    if (!has) begin
      if (v != 0) off_bad = 1'b1;
    end else begin
      deg = v - prev_off;
      if (v < prev_off) off_bad = 1'b1;
      if (deg <= lim_small) b = BIN_SMALL;
      else if (deg <= lim_large) b = BIN_MEDIUM;
      else b = BIN_LARGE;
      cnt[b]      = cnt[b] + 1;
      r.row_index = seen - 1;
      r.bin       = b;
    end
    prev_off = v;
    if (!has && !last) begin
      seen = 1;
      return 1'b0;
    end
    st = ST_OK;
    if (last) begin
      bad = (rows_cfg == 0) ? (edges_cfg != 0) : (off_bad || v != edges_cfg);
      if (lim_small >= lim_large) st = ST_BAD_THRESH;
      else if (bad) st = ST_BAD_OFFSETS;
      else if (cnt[BIN_SMALL] > cap[BIN_SMALL] || cnt[BIN_MEDIUM] > cap[BIN_MEDIUM] ||
               cnt[BIN_LARGE] > cap[BIN_LARGE]) st = ST_OVER_CAP;
    end
    r.has_row   = has;
    r.last      = last;
    r.status    = st;
    r.bin0_rows = cnt[BIN_SMALL];
    r.bin1_rows = cnt[BIN_MEDIUM];
    r.bin2_rows = cnt[BIN_LARGE];
    if (last) begin
      prev_off = '0;
      seen     = '0;
      cnt      = '{32'd0, 32'd0, 32'd0};
      off_bad  = 1'b0;
    end else begin
      seen = seen + 1;
    end
    return 1'b1;
  endfunction

  function automatic res_t mk_res(input bit has, input logic [31:0] row, input bin_e b,
                                  input bit last, input status_e st, input logic [31:0] n0,
                                  input logic [31:0] n1, input logic [31:0] n2);
    res_t r;
    r.has_row   = has;
    r.row_index = row;
    r.bin       = b;
    r.last      = last;
    r.status    = st;
    r.bin0_rows = n0;
    r.bin1_rows = n1;
    r.bin2_rows = n2;
    return r;
  endfunction

  function automatic step_t cfg_row(input cfg_idx_e idx, input logic [31:0] value);
    step_t s;
    s        = '{idx: CFG_SMALL_LIMIT, default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.value  = value;
    return s;
  endfunction

  function automatic step_t off_row(input logic [31:0] value);
    step_t s;
    s       = '{idx: CFG_SMALL_LIMIT, default: '0};
    s.value = value;
    return s;
  endfunction

  function automatic step_t chk_row(input logic [31:0] value, input res_t want);
    step_t s;
    s       = off_row(value);
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic logic [63:0] pick_degree(input logic [31:0] lo, input logic [31:0] hi);
    int which;
    which = $urandom_range(0, 2);
    if (which == 2 && hi != 32'hFFFF_FFFF)
      return {32'h0, hi} + 64'd1 +
             (($urandom_range(0, 3) == 0) ? {32'h0, $urandom} : 64'($urandom_range(0, 300)));
    if (which >= 1 && hi > lo)
      return {32'h0, lo} + 64'd1 + 64'($urandom_range(0, hi - lo - 1));
    return 64'($urandom_range(0, lo));
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_SMALL_LIMIT: lim_small = val;
      CFG_LARGE_LIMIT: lim_large = val;
      CFG_TOTAL_EDGES: edges_cfg = val;
      CFG_TOTAL_ROWS:  rows_cfg = val;
      CFG_BIN0_CAP:    cap[BIN_SMALL] = val;
      CFG_BIN1_CAP:    cap[BIN_MEDIUM] = val;
      CFG_BIN2_CAP:    cap[BIN_LARGE] = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_offset(input logic [31:0] v, input bit typed, input res_t typed_res);
    res_t r;
    while (!steady && $urandom_range(0, 99) < 35) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.offset <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (classify_offset(v, r)) pending_rows.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // also covers an offset still in flight that gives no result
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic play_table();
    logic [31:0] offs [$];
    logic [31:0] s_lim, l_lim, edges_new;
    logic [31:0] caps_new [3];
    logic [63:0] cur, d;
    int unsigned n, i;
    int          kind;
    bit          fresh, new_lims, new_caps;
    kind     = $urandom_range(0, 99);
    fresh    = ($urandom_range(0, 2) != 0) || (rows_cfg > 40);
    new_lims = $urandom_range(0, 3) == 0;
    new_caps = $urandom_range(0, 1);
    cur      = '0;
    if (fresh) begin
      i = $urandom_range(0, 99);
      n = (i < 5) ? 0 : (i < 90) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      s_lim = lim_small;
      l_lim = lim_large;
      if (new_lims) begin
        case ($urandom_range(0, 5))
          0: begin
            s_lim = 0;
            l_lim = $urandom_range(1, 20);
          end
          1: begin
            s_lim = $urandom_range(0, 40);
            l_lim = $urandom_range(0, s_lim);
          end
          2: begin
            s_lim = 32'hFFFF_FFFE;
            l_lim = 32'hFFFF_FFFF;
          end
          3: begin
            s_lim = $urandom_range(0, 32'h00FF_FFFF);
            l_lim = s_lim + $urandom_range(1, 32'h0FFF_FFFF);
          end
          default: begin
            s_lim = $urandom_range(0, 20);
            l_lim = s_lim + $urandom_range(1, 60);
          end
        endcase
      end
      for (i = 0; i < 3; i++) begin
        case ($urandom_range(0, 3))
          0:       caps_new[i] = 32'h0;
          1:       caps_new[i] = 32'hFFFF_FFFF;
          default: caps_new[i] = $urandom_range(0, n + 1);
        endcase
      end
      offs.push_back((kind >= 85 || (n == 0 && $urandom_range(0, 1))) ? $urandom : 32'h0);
      for (i = 0; i < n; i++) begin
        d   = pick_degree(s_lim, l_lim);
        cur = (cur + d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cur + d;
        offs.push_back((kind >= 85) ? $urandom : cur[31:0]);
      end
      edges_new = offs[n];
      if (n == 0) edges_new = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
      else if (kind >= 85 && $urandom_range(0, 1)) edges_new = $urandom;
      else if (kind >= 70 && kind < 85) begin
        case ($urandom_range(0, 2))
          0: offs[0] = $urandom_range(1, 32'hFFFF_FFFF);
          1: begin
            i = $urandom_range(1, n);
            if (offs[i-1] == 0) offs[i-1] = $urandom_range(1, 100);
            offs[i] = $urandom_range(0, offs[i-1] - 1);
          end
          default: edges_new = offs[n] + 1 + $urandom_range(0, 1000);
        endcase
      end
      wait_idle();
      if (new_lims) begin
        write_reg(CFG_SMALL_LIMIT, s_lim);
        write_reg(CFG_LARGE_LIMIT, l_lim);
      end
      if (new_caps) begin
        write_reg(CFG_BIN0_CAP, caps_new[0]);
        write_reg(CFG_BIN1_CAP, caps_new[1]);
        write_reg(CFG_BIN2_CAP, caps_new[2]);
      end
      if (n != rows_cfg) write_reg(CFG_TOTAL_ROWS, n);
      write_reg(CFG_TOTAL_EDGES, edges_new);
      cfg_if.valid <= 1'b0;
    end else begin
      // same settings: the table streams right behind the previous one
      n = rows_cfg;
      if (kind >= 85 || n == 0) begin
        for (i = 0; i <= n; i++) offs.push_back($urandom);
      end else begin
        offs.push_back(32'h0);
        for (i = 1; i < n; i++) begin
          cur = cur + ($urandom_range(0, edges_cfg - cur[31:0]) >> $urandom_range(0, 4));
          offs.push_back(cur[31:0]);
        end
        offs.push_back(edges_cfg);
      end
    end
    foreach (offs[k]) begin
      steady = offsets_sent >= SteadyFrom && offsets_sent < SteadyTo;
      send_offset(offs[k], 1'b0, '0);
      offsets_sent++;
    end
  endtask

  initial out_if.ready = 1'b0;

  always @(negedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.has_row, out_if.row_index, out_if.bin, out_if.last, out_if.status,
             out_if.bin0_rows, out_if.bin1_rows, out_if.bin2_rows};
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %p", $time, got);
      end else begin
        want = pending_rows.pop_front();
        compare_field("has_row", want.has_row, got.has_row);
        compare_field("row_index", want.row_index, got.row_index);
        compare_field("bin", want.bin, got.bin);
        compare_field("last", want.last, got.last);
        compare_field("status", want.status, got.status);
        compare_field("bin0_rows", want.bin0_rows, got.bin0_rows);
        compare_field("bin1_rows", want.bin1_rows, got.bin1_rows);
        compare_field("bin2_rows", want.bin2_rows, got.bin2_rows);
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    bit was_cfg;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.offset = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SMALL_LIMIT;
    cfg_if.data  = '0;
    was_cfg      = 1'b0;
    plan = '{
      // empty tables, value ignored, first under reset settings, then with a nonzero edge count
      chk_row(32'h0, mk_res(0, 0, BIN_SMALL, 1, ST_OK, 0, 0, 0)),
      chk_row(32'hFFFF_FFFF, mk_res(0, 0, BIN_SMALL, 1, ST_OK, 0, 0, 0)),
      cfg_row(CFG_TOTAL_EDGES, 32'd5),
      chk_row(32'h0, mk_res(0, 0, BIN_SMALL, 1, ST_BAD_OFFSETS, 0, 0, 0)),
      // small limit not below the large limit
      cfg_row(CFG_SMALL_LIMIT, 32'hFFFF_FFFF),
      cfg_row(CFG_LARGE_LIMIT, 32'hFFFF_FFFF),
      chk_row(32'd7, mk_res(0, 0, BIN_SMALL, 1, ST_BAD_THRESH, 0, 0, 0)),
      // one row per bin, final offset at the top of the range
      cfg_row(CFG_SMALL_LIMIT, 32'd2),
      cfg_row(CFG_LARGE_LIMIT, 32'd10),
      cfg_row(CFG_TOTAL_EDGES, 32'hFFFF_FFFF),
      cfg_row(CFG_TOTAL_ROWS, 32'd3),
      cfg_row(CFG_BIN0_CAP, 32'hFFFF_FFFF),
      cfg_row(CFG_BIN1_CAP, 32'hFFFF_FFFF),
      cfg_row(CFG_BIN2_CAP, 32'hFFFF_FFFF),
      off_row(32'h0),
      chk_row(32'd2, mk_res(1, 0, BIN_SMALL, 0, ST_OK, 1, 0, 0)),
      chk_row(32'd12, mk_res(1, 1, BIN_MEDIUM, 0, ST_OK, 1, 1, 0)),
      chk_row(32'hFFFF_FFFF, mk_res(1, 2, BIN_LARGE, 1, ST_OK, 1, 1, 1)),
      // over capacity
      cfg_row(CFG_BIN0_CAP, 32'h0),
      cfg_row(CFG_BIN1_CAP, 32'h0),
      cfg_row(CFG_BIN2_CAP, 32'h0),
      cfg_row(CFG_TOTAL_EDGES, 32'd3),
      cfg_row(CFG_TOTAL_ROWS, 32'd2),
      off_row(32'h0),
      off_row(32'd3),
      chk_row(32'd3, mk_res(1, 1, BIN_SMALL, 1, ST_OVER_CAP, 1, 1, 0)),
      // decreasing offset
      off_row(32'h0),
      off_row(32'd5),
      chk_row(32'd3, mk_res(1, 1, BIN_LARGE, 1, ST_BAD_OFFSETS, 0, 1, 1)),
      // first offset not zero
      off_row(32'd1),
      off_row(32'd2),
      chk_row(32'd3, mk_res(1, 1, BIN_SMALL, 1, ST_BAD_OFFSETS, 2, 0, 0)),
      // final offset off the edge count
      off_row(32'h0),
      off_row(32'd1),
      chk_row(32'd2, mk_res(1, 1, BIN_SMALL, 1, ST_BAD_OFFSETS, 2, 0, 0)),
      // huge row count, cut short by a write inside the table
      cfg_row(CFG_TOTAL_ROWS, 32'hFFFF_FFFE),
      off_row(32'h0),
      off_row(32'd4),
      cfg_row(CFG_TOTAL_ROWS, 32'd2),
      cfg_row(CFG_TOTAL_EDGES, 32'd4),
      chk_row(32'd4, mk_res(1, 1, BIN_SMALL, 1, ST_OVER_CAP, 1, 1, 0))
    };
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < NumSteps; k++) begin
      if (plan[k].is_cfg) begin
        if (!was_cfg) wait_idle();
        write_reg(plan[k].idx, plan[k].value);
      end else begin
        if (was_cfg) cfg_if.valid <= 1'b0;
        send_offset(plan[k].value, plan[k].typed, plan[k].want);
      end
      was_cfg = plan[k].is_cfg;
    end

    while (offsets_sent < RandomOffsets) play_table();
    steady = 1'b0;
    wait_idle();

    if (errors == 0 && pending_rows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- csr_row_degree_binner_top.f -----
rtl/core/crdb_pkg.sv
rtl/core/crdb_in_if.sv
rtl/core/crdb_out_if.sv
rtl/core/crdb_cfg_if.sv
rtl/core/crdb_cfg_regs.sv
rtl/core/crdb_front.sv
rtl/core/crdb_queue.sv
rtl/core/crdb_back.sv
rtl/core/csr_row_degree_binner_top.sv
tb/sv/csr_row_degree_binner_top_tb.sv
